// ----- src/h2st_pkg.sv -----
// ----------------------------------------------------------------------------
// h2st_pkg
// Shared types, codes and constants of the HTTP/2 stream state tracker.
// ----------------------------------------------------------------------------
package h2st_pkg;

  localparam int STREAM_SLOTS = 64;
  localparam int IDX_W        = $clog2(STREAM_SLOTS);
  localparam int CNT_W        = $clog2(STREAM_SLOTS + 1);
  localparam int SET_N        = 6;

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_RES_REMOTE = 3'd2;
  localparam logic [2:0] ST_OPEN       = 3'd3;
  localparam logic [2:0] ST_HC_LOCAL   = 3'd4;
  localparam logic [2:0] ST_HC_REMOTE  = 3'd5;
  localparam logic [2:0] ST_CLOSED     = 3'd6;

  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_PROTO    = 3'd1;
  localparam logic [2:0] E_PING     = 3'd2;
  localparam logic [2:0] E_COMPRESS = 3'd3;
  localparam logic [2:0] E_INTERNAL = 3'd4;

  localparam logic [3:0] C_DATA     = 4'd0;
  localparam logic [3:0] C_HEADERS  = 4'd1;
  localparam logic [3:0] C_PRIORITY = 4'd2;
  localparam logic [3:0] C_RST      = 4'd3;
  localparam logic [3:0] C_SETTINGS = 4'd4;
  localparam logic [3:0] C_PUSH     = 4'd5;
  localparam logic [3:0] C_PING     = 4'd6;
  localparam logic [3:0] C_WUPDATE  = 4'd8;
  localparam logic [3:0] C_CONT     = 4'd9;

  localparam int F_END_STREAM  = 0;
  localparam int F_END_HEADERS = 2;
  localparam int F_PRIORITY    = 5;

  localparam logic [15:0] KEY_INIT_WINDOW = 16'd4;
  localparam logic [15:0] KEY_LAST        = 16'd6;
  localparam int SET_PUSH = 1;
  localparam int SET_INIT = 3;
  localparam int SET_MAXF = 4;

  typedef struct packed {
    logic        direction;
    logic [3:0]  cmd;
    logic [30:0] stream_id;
    logic [23:0] frame_length;
    logic [7:0]  frame_flags;
    logic [15:0] setting_key;
    logic [31:0] payload_value;
    logic [7:0]  priority_weight;
    logic        hpack_ok;
  } item_t;

  typedef struct packed {
    logic [30:0]        stream_id;
    logic [2:0]         status;
    logic signed [31:0] rx_win;
    logic signed [31:0] tx_win;
    logic [7:0]         weight;
    logic [31:0]        dependency;
    logic [31:0]        reset_code;
  } slot_rec_t;

  function automatic logic [31:0] set_default(input int idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'd4096;
      1:       v = 32'd1;
      3:       v = 32'd65535;
      4:       v = 32'd16384;
      default: v = 32'hFFFF_FFFF;
    endcase
    return v;
  endfunction

  function automatic logic signed [33:0] sx34(input logic [31:0] x);
    return {{2{x[31]}}, x};
  endfunction

  function automatic logic signed [33:0] zx34(input logic [31:0] x);
    return {2'b00, x};
  endfunction

endpackage

// ----- src/h2st_in_if.sv -----
// ----------------------------------------------------------------------------
// h2st_in_if
// Frame event channel: valid, ready and one frame header or settings pair.
// ----------------------------------------------------------------------------
interface h2st_in_if;
  logic        valid;
  logic        ready;
  logic        direction;
  logic [3:0]  cmd;
  logic [30:0] stream_id;
  logic [23:0] frame_length;
  logic [7:0]  frame_flags;
  logic [15:0] setting_key;
  logic [31:0] payload_value;
  logic [7:0]  priority_weight;
  logic        hpack_ok;

  modport source (output valid, direction, cmd, stream_id, frame_length, frame_flags,
                  setting_key, payload_value, priority_weight, hpack_ok, input ready);
  modport sink (input valid, direction, cmd, stream_id, frame_length, frame_flags,
                setting_key, payload_value, priority_weight, hpack_ok, output ready);
endinterface

// ----- src/h2st_out_if.sv -----
// ----------------------------------------------------------------------------
// h2st_out_if
// Result channel: valid, ready, error code and window readback.
// ----------------------------------------------------------------------------
interface h2st_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         error_code;
  logic [2:0]         stream_status;
  logic signed [31:0] stream_recv_window;
  logic signed [31:0] stream_send_window;
  logic signed [31:0] conn_recv_window;
  logic signed [31:0] conn_send_window;

  modport source (output valid, error_code, stream_status, stream_recv_window,
                  stream_send_window, conn_recv_window, conn_send_window, input ready);
  modport sink (input valid, error_code, stream_status, stream_recv_window,
                stream_send_window, conn_recv_window, conn_send_window, output ready);
endinterface

// ----- src/http2_stream_state_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// http2_stream_state_tracker_unit
// HTTP/2 stream table, state rules and flow-control windows under a sequencer.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | content
//  in_ch    | in  | valid / ready    | frame header or settings pair
//  out_ch   | out | valid / ready    | error code, stream and connection windows
//  cfg_*    | in  | cfg_we           | expected ping opaque
//
//  The lookup reads and compares each table entry in turn when the stream id is
//  at or below the highest id seen (linear search through the slot memory).
//  A new stream adds the receive and send window allocation; data adds the
//  connection window update; a push promise adds its own lookup of the promised
//  id. An initial window setting rebases the connection and allocated slots.
//  Slots fill in order under a fill count; reset does no clearing.
//  in_ch.ready is high only in the idle state; one finished result may wait.
// ----------------------------------------------------------------------------
module http2_stream_state_tracker_unit import h2st_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  h2st_in_if.sink     in_ch,
  h2st_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CMP = 4'd2;
  localparam logic [3:0] S_ALLOC_R  = 4'd3;
  localparam logic [3:0] S_ALLOC_S  = 4'd4;
  localparam logic [3:0] S_EXEC     = 4'd5;
  localparam logic [3:0] S_OP2      = 4'd6;
  localparam logic [3:0] S_WB       = 4'd7;
  localparam logic [3:0] S_PUSH     = 4'd8;
  localparam logic [3:0] S_PEXEC    = 4'd9;
  localparam logic [3:0] S_RB_CONN  = 4'd10;
  localparam logic [3:0] S_RB_RD    = 4'd11;
  localparam logic [3:0] S_RB_WR    = 4'd12;
  localparam logic [3:0] S_OUT      = 4'd13;

  logic [3:0]         state_r, state_nxt;
  item_t              itm_r, itm_nxt;
  slot_rec_t          cur_r, cur_nxt;
  logic [IDX_W-1:0]   s_r, s_nxt;
  logic               s_ok_r, s_ok_nxt;
  logic               full_r, full_nxt;
  logic               second_r, second_nxt;
  logic               push_r, push_nxt;
  logic [30:0]        lk_id_r, lk_id_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [30:0]        high_r, high_nxt;
  logic [30:0]        open_r, open_nxt;
  logic [30:0]        prev_r, prev_nxt;
  logic [31:0]        peer_r [SET_N];
  logic [31:0]        peer_nxt [SET_N];
  logic [31:0]        local_r [SET_N];
  logic [31:0]        local_nxt [SET_N];
  logic signed [31:0] crw_r, crw_nxt;
  logic signed [31:0] csw_r, csw_nxt;
  logic [32:0]        d_r, d_nxt;
  logic [2:0]         err_r, err_nxt;
  logic [2:0]         sn_stat_r, sn_stat_nxt;
  logic signed [31:0] sn_rw_r, sn_rw_nxt;
  logic signed [31:0] sn_sw_r, sn_sw_nxt;
  logic [31:0]        ping_r;
  logic               ov_r, ov_nxt;
  logic [2:0]         o_err_r, o_err_nxt;
  logic [2:0]         o_stat_r, o_stat_nxt;
  logic signed [31:0] o_rw_r, o_rw_nxt;
  logic signed [31:0] o_sw_r, o_sw_nxt;
  logic signed [31:0] o_crw_r, o_crw_nxt;
  logic signed [31:0] o_csw_r, o_csw_nxt;

  slot_rec_t          slot_mem [STREAM_SLOTS];
  slot_rec_t          mem_q_r;
  slot_rec_t          mem_wdata;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [IDX_W-1:0]   mem_raddr;

  logic signed [33:0] alu_a, alu_b;
  logic signed [34:0] alu_sum;
  logic signed [31:0] alu_sat;

  logic               in_acc;
  logic               lk_go;
  logic [30:0]        lk_src;
  logic               last_idx;
  logic [2:0]         kidx;
  logic               key_ok;
  logic [31:0]        set_init;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign last_idx = (CNT_W'(idx_r) + CNT_W'(1)) == cnt_r;
  assign kidx     = itm_r.setting_key[2:0] - 3'd1;
  assign key_ok   = (itm_r.setting_key != 16'd0) && (itm_r.setting_key <= KEY_LAST);
  assign set_init = itm_r.direction ? local_r[SET_INIT] : peer_r[SET_INIT];
  assign lk_src   = (state_r == S_IDLE) ? in_ch.stream_id : itm_r.payload_value[30:0];

  h2st_sat_alu u_alu (
    .op_a (alu_a),
    .op_b (alu_b),
    .sum  (alu_sum),
    .sat  (alu_sat)
  );

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state_r)
      S_ALLOC_R: alu_b = zx34(peer_r[SET_INIT]);
      S_ALLOC_S: alu_b = zx34(local_r[SET_INIT]);
      S_EXEC: begin
        if (itm_r.cmd == C_DATA) begin
          alu_a = itm_r.direction ? sx34(cur_r.tx_win) : sx34(cur_r.rx_win);
          alu_b = 34'sd0 - zx34({8'd0, itm_r.frame_length});
        end else if (itm_r.cmd == C_WUPDATE) begin
          if (itm_r.direction) begin
            alu_a = s_ok_r ? sx34(cur_r.rx_win) : sx34(crw_r);
          end else begin
            alu_a = s_ok_r ? sx34(cur_r.tx_win) : sx34(csw_r);
          end
          alu_b = zx34({1'b0, itm_r.payload_value[30:0]});
        end else begin
          alu_a = zx34(itm_r.payload_value);
          alu_b = 34'sd0 - zx34(set_init);
        end
      end
      S_OP2: begin
        alu_a = itm_r.direction ? sx34(csw_r) : sx34(crw_r);
        alu_b = 34'sd0 - zx34({8'd0, itm_r.frame_length});
      end
      S_RB_CONN: begin
        alu_a = itm_r.direction ? sx34(csw_r) : sx34(crw_r);
        alu_b = {d_r[32], d_r};
      end
      S_RB_WR: begin
        alu_a = itm_r.direction ? sx34(mem_q_r.tx_win) : sx34(mem_q_r.rx_win);
        alu_b = {d_r[32], d_r};
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    itm_nxt     = itm_r;
    cur_nxt     = cur_r;
    s_nxt       = s_r;
    s_ok_nxt    = s_ok_r;
    full_nxt    = full_r;
    second_nxt  = second_r;
    push_nxt    = push_r;
    lk_id_nxt   = lk_id_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    high_nxt    = high_r;
    open_nxt    = open_r;
    prev_nxt    = prev_r;
    peer_nxt    = peer_r;
    local_nxt   = local_r;
    crw_nxt     = crw_r;
    csw_nxt     = csw_r;
    d_nxt       = d_r;
    err_nxt     = err_r;
    sn_stat_nxt = sn_stat_r;
    sn_rw_nxt   = sn_rw_r;
    sn_sw_nxt   = sn_sw_r;
    ov_nxt      = ov_r;
    o_err_nxt   = o_err_r;
    o_stat_nxt  = o_stat_r;
    o_rw_nxt    = o_rw_r;
    o_sw_nxt    = o_sw_r;
    o_crw_nxt   = o_crw_r;
    o_csw_nxt   = o_csw_r;
    mem_we      = 1'b0;
    mem_waddr   = s_r;
    mem_wdata   = cur_r;
    mem_raddr   = idx_r;
    lk_go       = 1'b0;

    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          itm_nxt.direction       = in_ch.direction;
          itm_nxt.cmd             = in_ch.cmd;
          itm_nxt.stream_id       = in_ch.stream_id;
          itm_nxt.frame_length    = in_ch.frame_length;
          itm_nxt.frame_flags     = in_ch.frame_flags;
          itm_nxt.setting_key     = in_ch.setting_key;
          itm_nxt.payload_value   = in_ch.payload_value;
          itm_nxt.priority_weight = in_ch.priority_weight;
          itm_nxt.hpack_ok        = in_ch.hpack_ok;
          err_nxt    = E_NONE;
          second_nxt = 1'b0;
          push_nxt   = 1'b0;
          lk_go      = 1'b1;
        end
      end
      S_PUSH: begin
        second_nxt = 1'b1;
        push_nxt   = 1'b0;
        lk_go      = 1'b1;
      end
      S_SCAN_RD: begin
        mem_raddr = idx_r;
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (mem_q_r.stream_id == lk_id_r) begin
          cur_nxt  = mem_q_r;
          s_nxt    = idx_r;
          s_ok_nxt = 1'b1;
          if (mem_q_r.status == ST_IDLE && lk_id_r < high_r) begin
            cur_nxt.status = ST_CLOSED;
          end
          state_nxt = second_r ? S_PEXEC : S_EXEC;
        end else if (last_idx) begin
          if (cnt_r == CNT_W'(STREAM_SLOTS)) begin
            full_nxt  = 1'b1;
            s_ok_nxt  = 1'b0;
            state_nxt = second_r ? S_PEXEC : S_EXEC;
          end else begin
            cur_nxt   = '{lk_id_r, ST_CLOSED, '0, '0, '0, '0, '0};
            s_nxt     = cnt_r[IDX_W-1:0];
            cnt_nxt   = cnt_r + CNT_W'(1);
            s_ok_nxt  = 1'b1;
            state_nxt = S_ALLOC_R;
          end
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_ALLOC_R: begin
        cur_nxt.rx_win = alu_sat;
        state_nxt = S_ALLOC_S;
      end
      S_ALLOC_S: begin
        cur_nxt.tx_win = alu_sat;
        state_nxt = second_r ? S_PEXEC : S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_WB;
        if (full_r) begin
          err_nxt = E_INTERNAL;
        end else if (!itm_r.direction) begin
          if ({8'd0, itm_r.frame_length} > peer_r[SET_MAXF]) begin
            err_nxt = E_PROTO;
          end else begin
            prev_nxt = itm_r.stream_id;
            if (open_r != 31'd0 && itm_r.cmd != C_CONT) begin
              err_nxt = E_PROTO;
            end else begin
              case (itm_r.cmd)
                C_PING: begin
                  if (itm_r.stream_id != 31'd0) begin
                    err_nxt = E_PROTO;
                  end else if (itm_r.frame_flags[F_END_STREAM] &&
                               itm_r.payload_value != ping_r) begin
                    err_nxt = E_PING;
                  end
                end
                C_DATA: begin
                  if (!s_ok_r || (cur_r.status != ST_OPEN && cur_r.status != ST_HC_LOCAL)) begin
                    err_nxt = E_PROTO;
                  end else begin
                    cur_nxt.rx_win = alu_sat;
                    if (itm_r.frame_flags[F_END_STREAM]) begin
                      cur_nxt.status = (cur_r.status == ST_HC_LOCAL) ? ST_CLOSED : ST_HC_REMOTE;
                    end
                    state_nxt = S_OP2;
                  end
                end
                C_HEADERS: begin
                  if (!s_ok_r || cur_r.status != ST_IDLE) begin
                    err_nxt = E_PROTO;
                  end else begin
                    cur_nxt.status = ST_OPEN;
                    if (itm_r.frame_flags[F_PRIORITY]) begin
                      cur_nxt.weight     = itm_r.priority_weight;
                      cur_nxt.dependency = itm_r.payload_value;
                    end
                    if (itm_r.frame_flags[F_END_STREAM]) begin
                      cur_nxt.status = ST_HC_REMOTE;
                    end
                    if (itm_r.frame_flags[F_END_HEADERS]) begin
                      err_nxt = itm_r.hpack_ok ? E_NONE : E_COMPRESS;
                    end else begin
                      open_nxt = itm_r.stream_id;
                    end
                  end
                end
                C_CONT: begin
                  if (itm_r.stream_id != prev_r || !s_ok_r) begin
                    err_nxt = E_PROTO;
                  end else if (open_r != itm_r.stream_id) begin
                    err_nxt = E_INTERNAL;
                  end else if (itm_r.frame_flags[F_END_HEADERS]) begin
                    open_nxt = 31'd0;
                    err_nxt  = itm_r.hpack_ok ? E_NONE : E_COMPRESS;
                  end
                end
                C_WUPDATE: begin
                  if (s_ok_r) begin
                    cur_nxt.tx_win = alu_sat;
                  end else begin
                    csw_nxt = alu_sat;
                  end
                end
                C_SETTINGS: begin
                  if (itm_r.stream_id != 31'd0) begin
                    err_nxt = E_PROTO;
                  end else if (!itm_r.frame_flags[F_END_STREAM] && key_ok) begin
                    peer_nxt[kidx] = itm_r.payload_value;
                    if (itm_r.setting_key == KEY_INIT_WINDOW) begin
                      d_nxt     = alu_sum[32:0];
                      state_nxt = S_RB_CONN;
                    end
                  end
                end
                C_RST: begin
                  if (!s_ok_r || cur_r.status == ST_IDLE) begin
                    err_nxt = E_PROTO;
                  end else begin
                    cur_nxt.reset_code = itm_r.payload_value;
                    cur_nxt.status     = ST_CLOSED;
                  end
                end
                C_PRIORITY: begin
                  if (!s_ok_r) begin
                    err_nxt = E_PROTO;
                  end else begin
                    cur_nxt.weight     = itm_r.priority_weight;
                    cur_nxt.dependency = itm_r.payload_value;
                  end
                end
                C_PUSH: begin
                  if (peer_r[SET_PUSH] == 32'd0 || !s_ok_r ||
                      (cur_r.status != ST_OPEN && cur_r.status != ST_HC_REMOTE)) begin
                    err_nxt = E_PROTO;
                  end else begin
                    push_nxt = 1'b1;
                  end
                end
                default: err_nxt = E_NONE;
              endcase
            end
          end
        end else begin
          case (itm_r.cmd)
            C_DATA: begin
              if (!s_ok_r || (cur_r.status != ST_OPEN && cur_r.status != ST_HC_REMOTE)) begin
                err_nxt = E_PROTO;
              end else begin
                cur_nxt.tx_win = alu_sat;
                if (itm_r.frame_flags[F_END_STREAM]) begin
                  cur_nxt.status = (cur_r.status == ST_HC_REMOTE) ? ST_CLOSED : ST_HC_LOCAL;
                end
                state_nxt = S_OP2;
              end
            end
            C_HEADERS: begin
              if (!s_ok_r || cur_r.status != ST_IDLE) begin
                err_nxt = E_PROTO;
              end else begin
                cur_nxt.status = ST_OPEN;
                if (itm_r.frame_flags[F_PRIORITY]) begin
                  cur_nxt.weight     = itm_r.priority_weight;
                  cur_nxt.dependency = itm_r.payload_value;
                end
                if (itm_r.frame_flags[F_END_STREAM]) begin
                  cur_nxt.status = ST_HC_LOCAL;
                end
              end
            end
            C_WUPDATE: begin
              if (s_ok_r) begin
                cur_nxt.rx_win = alu_sat;
              end else begin
                crw_nxt = alu_sat;
              end
            end
            C_RST: begin
              if (!s_ok_r) begin
                err_nxt = E_PROTO;
              end else begin
                cur_nxt.reset_code = itm_r.payload_value;
                cur_nxt.status     = ST_CLOSED;
              end
            end
            C_SETTINGS: begin
              if (itm_r.stream_id != 31'd0) begin
                err_nxt = E_PROTO;
              end else if (!itm_r.frame_flags[F_END_STREAM] && key_ok) begin
                local_nxt[kidx] = itm_r.payload_value;
                if (itm_r.setting_key == KEY_INIT_WINDOW) begin
                  d_nxt     = alu_sum[32:0];
                  state_nxt = S_RB_CONN;
                end
              end
            end
            default: err_nxt = E_INTERNAL;
          endcase
        end
      end
      S_OP2: begin
        if (itm_r.direction) begin
          csw_nxt = alu_sat;
        end else begin
          crw_nxt = alu_sat;
        end
        state_nxt = S_WB;
      end
      S_PEXEC: begin
        state_nxt = S_WB;
        if (full_r) begin
          err_nxt = E_INTERNAL;
        end else if (!s_ok_r || cur_r.status != ST_IDLE) begin
          err_nxt = E_PROTO;
        end else begin
          cur_nxt.status = ST_RES_REMOTE;
          if (itm_r.frame_flags[F_END_HEADERS]) begin
            err_nxt = itm_r.hpack_ok ? E_NONE : E_COMPRESS;
          end else begin
            open_nxt = itm_r.payload_value[30:0];
          end
        end
      end
      S_RB_CONN: begin
        if (itm_r.direction) begin
          csw_nxt = alu_sat;
        end else begin
          crw_nxt = alu_sat;
        end
        idx_nxt   = '0;
        state_nxt = (cnt_r == CNT_W'(0)) ? S_WB : S_RB_RD;
      end
      S_RB_RD: begin
        mem_raddr = idx_r;
        state_nxt = S_RB_WR;
      end
      S_RB_WR: begin
        mem_wdata = mem_q_r;
        if (itm_r.direction) begin
          mem_wdata.tx_win = alu_sat;
        end else begin
          mem_wdata.rx_win = alu_sat;
        end
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        if (last_idx) begin
          state_nxt = S_WB;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_RB_RD;
        end
      end
      S_WB: begin
        if (s_ok_r) begin
          mem_we    = 1'b1;
          mem_waddr = s_r;
          mem_wdata = cur_r;
        end
        if (!second_r) begin
          sn_stat_nxt = s_ok_r ? cur_r.status : 3'd0;
          sn_rw_nxt   = s_ok_r ? cur_r.rx_win : 32'sd0;
          sn_sw_nxt   = s_ok_r ? cur_r.tx_win : 32'sd0;
        end
        state_nxt = push_r ? S_PUSH : S_OUT;
      end
      S_OUT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt     = 1'b1;
          o_err_nxt  = err_r;
          o_stat_nxt = sn_stat_r;
          o_rw_nxt   = sn_rw_r;
          o_sw_nxt   = sn_sw_r;
          o_crw_nxt  = crw_r;
          o_csw_nxt  = csw_r;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (lk_go) begin
      lk_id_nxt = lk_src;
      full_nxt  = 1'b0;
      s_ok_nxt  = 1'b0;
      if (lk_src == 31'd0) begin
        state_nxt = second_nxt ? S_PEXEC : S_EXEC;
      end else if (lk_src > high_r || cnt_r == CNT_W'(0)) begin
        if (cnt_r == CNT_W'(STREAM_SLOTS)) begin
          full_nxt  = 1'b1;
          state_nxt = second_nxt ? S_PEXEC : S_EXEC;
        end else begin
          cur_nxt   = '{lk_src, (lk_src > high_r) ? ST_IDLE : ST_CLOSED, '0, '0, '0, '0, '0};
          s_nxt     = cnt_r[IDX_W-1:0];
          cnt_nxt   = cnt_r + CNT_W'(1);
          s_ok_nxt  = 1'b1;
          if (lk_src > high_r) begin
            high_nxt = lk_src;
          end
          state_nxt = S_ALLOC_R;
        end
      end else begin
        idx_nxt   = '0;
        state_nxt = S_SCAN_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= slot_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      high_r  <= '0;
      open_r  <= '0;
      prev_r  <= '0;
      crw_r   <= '0;
      csw_r   <= '0;
      ping_r  <= '0;
      ov_r    <= 1'b0;
      push_r  <= 1'b0;
      for (int i = 0; i < SET_N; i++) begin
        peer_r[i]  <= set_default(i);
        local_r[i] <= set_default(i);
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      high_r  <= high_nxt;
      open_r  <= open_nxt;
      prev_r  <= prev_nxt;
      crw_r   <= crw_nxt;
      csw_r   <= csw_nxt;
      ov_r    <= ov_nxt;
      push_r  <= push_nxt;
      peer_r  <= peer_nxt;
      local_r <= local_nxt;
      if (cfg_we) begin
        ping_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    itm_r     <= itm_nxt;
    cur_r     <= cur_nxt;
    s_r       <= s_nxt;
    s_ok_r    <= s_ok_nxt;
    full_r    <= full_nxt;
    second_r  <= second_nxt;
    lk_id_r   <= lk_id_nxt;
    idx_r     <= idx_nxt;
    d_r       <= d_nxt;
    err_r     <= err_nxt;
    sn_stat_r <= sn_stat_nxt;
    sn_rw_r   <= sn_rw_nxt;
    sn_sw_r   <= sn_sw_nxt;
    o_err_r   <= o_err_nxt;
    o_stat_r  <= o_stat_nxt;
    o_rw_r    <= o_rw_nxt;
    o_sw_r    <= o_sw_nxt;
    o_crw_r   <= o_crw_nxt;
    o_csw_r   <= o_csw_nxt;
  end

  assign out_ch.valid              = ov_r;
  assign out_ch.error_code         = o_err_r;
  assign out_ch.stream_status      = o_stat_r;
  assign out_ch.stream_recv_window = o_rw_r;
  assign out_ch.stream_send_window = o_sw_r;
  assign out_ch.conn_recv_window   = o_crw_r;
  assign out_ch.conn_send_window   = o_csw_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STREAM_SLOTS))
    else $error("fill count beyond table depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("ready while a transaction is in work");

  a_wb_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB && s_ok_r) |-> (CNT_W'(s_r) < cnt_r))
    else $error("write back to an unallocated slot");

  a_open_block: assert property (@(posedge clk) disable iff (!rst_n)
    (open_r != 31'd0) |-> (open_r <= high_r))
    else $error("open header block above highest stream id");

endmodule

// ----- src/h2st_sat_alu.sv -----
// ----------------------------------------------------------------------------
// h2st_sat_alu
// Shared window adder: wide sum and the sum clamped to 32-bit signed range.
// ----------------------------------------------------------------------------
module h2st_sat_alu (
  input  logic signed [33:0] op_a,
  input  logic signed [33:0] op_b,
  output logic signed [34:0] sum,
  output logic signed [31:0] sat
);

  always_comb begin
    sum = {op_a[33], op_a} + {op_b[33], op_b};
    if (!sum[34] && (|sum[33:31])) begin
      sat = {1'b0, {31{1'b1}}};
    end else if (sum[34] && !(&sum[33:31])) begin
      sat = {1'b1, {31{1'b0}}};
    end else begin
      sat = sum[31:0];
    end
  end

endmodule
